[rtl/core/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, hue constants and pipeline types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int HUE_W      = 15;

  // Divider: 20-bit dividend, 8-bit divisor, one quotient bit per stage.
  localparam int DIV_NUM_W  = 20;
  localparam int DIV_DEN_W  = CHAN_W;
  localparam int DIV_QUOT_W = 12;
  localparam int DIV_STAGES = DIV_QUOT_W;

  // Hue in degrees times 64.
  localparam logic [HUE_W-1:0] HUE_RED_OFFSET   = 15'd0;
  localparam logic [HUE_W-1:0] HUE_GREEN_OFFSET = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_OFFSET  = 15'd15360;
  localparam logic [HUE_W:0]   HUE_FULL_CIRCLE  = 16'd23040;

  // Per-pixel data that rides alongside the dividers.
  typedef struct packed {
    logic [CHAN_W-1:0] max_val;   // brightness
    logic              grey;      // delta is zero, hue forced to zero
    logic              neg;       // hue difference is negative
    logic [HUE_W-1:0]  offset;    // sector offset
  } side_t;

endpackage

[rtl/core/rhc_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_divider
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in DIV_QUOT_W bits; the final remainder is reported as nonzero or not.
// ----------------------------------------------------------------------------
module rhc_divider import rhc_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIV_NUM_W-1:0]  in_num,
  input  logic [DIV_DEN_W-1:0]  in_den,
  output logic [DIV_QUOT_W-1:0] out_quot,
  output logic                  out_rem_nz
);

  logic [DIV_NUM_W-1:0]  num_r  [DIV_STAGES];
  logic [DIV_QUOT_W-1:0] quot_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0]  den_r  [DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int Bit = DIV_STAGES - 1 - s;

    logic [DIV_NUM_W-1:0]  num_in;
    logic [DIV_DEN_W-1:0]  den_in;
    logic [DIV_QUOT_W-1:0] quot_in;
    logic [DIV_NUM_W-1:0]  shifted;
    logic                  fits;
    logic [DIV_NUM_W-1:0]  num_nxt;
    logic [DIV_QUOT_W-1:0] quot_nxt;

    if (s == 0) begin : g_first
      assign num_in  = in_num;
      assign den_in  = in_den;
      assign quot_in = '0;
    end else begin : g_next
      assign num_in  = num_r[s-1];
      assign den_in  = den_r[s-1];
      assign quot_in = quot_r[s-1];
    end

    assign shifted  = DIV_NUM_W'(den_in) << Bit;
    assign fits     = (num_in >= shifted);
    assign num_nxt  = fits ? (num_in - shifted) : num_in;
    assign quot_nxt = fits ? (quot_in | (DIV_QUOT_W'(1) << Bit)) : quot_in;

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s]  <= num_nxt;
        quot_r[s] <= quot_nxt;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign out_quot   = quot_r[DIV_STAGES-1];
  assign out_rem_nz = |num_r[DIV_STAGES-1];

endmodule

[rtl/core/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts packed 24-bit RGB pixels to hue, saturation and value.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / in_pixel_rgb (red 7:0, green 15:8,
// blue 23:16). Result channel: out_valid / out_stall / out_hue (degrees
// times 64, 0 to 23039), out_saturation (255 = full), out_brightness (max).
// A transfer happens on a rising edge with valid high and stall low.
//
// One pixel enters per clock, every clock, as long as the receiver keeps
// taking results. The stages are: min/max search, delta and dividend
// setup, twelve restoring divider stages (one quotient bit each, hue and
// saturation dividers side by side), then the hue offset/wrap and the
// output register. The twelve divider stages set the depth.
//
// Reset empties every stage; no result is shown until a pixel goes through.
// When the output register holds a result and out_stall is high, the whole
// pipeline holds and in_stall goes high in the same cycle, so nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIXEL_W-1:0] in_pixel_rgb,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [HUE_W-1:0]   out_hue,
  output logic [CHAN_W-1:0]  out_saturation,
  output logic [CHAN_W-1:0]  out_brightness
);

  logic advance;

  // Stage 1: unpack, max and min.
  logic              s1_valid_r;
  logic [CHAN_W-1:0] s1_red_r, s1_green_r, s1_blue_r, s1_max_r, s1_min_r;
  logic [CHAN_W-1:0] red_in, green_in, blue_in, max_nxt, min_nxt;

  // Stage 2: dividends and sector data.
  logic                 s2_valid_r;
  logic [DIV_NUM_W-1:0] s2_hue_num_r, s2_sat_num_r;
  logic [CHAN_W-1:0]    s2_delta_r;
  side_t                s2_side_r;
  logic [CHAN_W-1:0]    delta_nxt, diff_a, diff_b, abs_diff;
  logic [DIV_NUM_W-1:0] hue_num_nxt, sat_num_nxt;
  side_t                side_nxt;

  // Divider stages.
  logic                  div_valid_r [DIV_STAGES];
  side_t                 div_side_r  [DIV_STAGES];
  logic [DIV_QUOT_W-1:0] hue_quot, sat_quot;
  logic                  hue_rem_nz, sat_rem_nz;

  // Output register.
  logic              out_valid_r;
  logic [HUE_W-1:0]  out_hue_r, hue_nxt;
  logic [CHAN_W-1:0] out_sat_r, sat_nxt, out_bright_r;
  logic [HUE_W:0]    hue_sum;
  side_t             last_side;

  assign in_stall = out_valid_r & out_stall;
  assign advance  = ~in_stall;

  // ---- stage 1 ----
  assign red_in   = in_pixel_rgb[CHAN_W-1:0];
  assign green_in = in_pixel_rgb[2*CHAN_W-1:CHAN_W];
  assign blue_in  = in_pixel_rgb[3*CHAN_W-1:2*CHAN_W];

  always_comb begin
    max_nxt = red_in;
    if (green_in > max_nxt) max_nxt = green_in;
    if (blue_in > max_nxt) max_nxt = blue_in;
    min_nxt = red_in;
    if (green_in < min_nxt) min_nxt = green_in;
    if (blue_in < min_nxt) min_nxt = blue_in;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_red_r   <= red_in;
      s1_green_r <= green_in;
      s1_blue_r  <= blue_in;
      s1_max_r   <= max_nxt;
      s1_min_r   <= min_nxt;
    end
  end

  // ---- stage 2 ----
  always_comb begin
    delta_nxt = s1_max_r - s1_min_r;
    // Ties go to red, then green.
    priority if (s1_max_r == s1_red_r) begin
      diff_a          = s1_green_r;
      diff_b          = s1_blue_r;
      side_nxt.offset = HUE_RED_OFFSET;
    end else if (s1_max_r == s1_green_r) begin
      diff_a          = s1_blue_r;
      diff_b          = s1_red_r;
      side_nxt.offset = HUE_GREEN_OFFSET;
    end else begin
      diff_a          = s1_red_r;
      diff_b          = s1_green_r;
      side_nxt.offset = HUE_BLUE_OFFSET;
    end
    side_nxt.neg     = (diff_a < diff_b);
    abs_diff         = side_nxt.neg ? (diff_b - diff_a) : (diff_a - diff_b);
    side_nxt.max_val = s1_max_r;
    side_nxt.grey    = (delta_nxt == '0);
    // 3840 * |diff| and 255 * delta, by shift and subtract.
    hue_num_nxt = (DIV_NUM_W'(abs_diff) << 12) - (DIV_NUM_W'(abs_diff) << 8);
    sat_num_nxt = (DIV_NUM_W'(delta_nxt) << 8) - DIV_NUM_W'(delta_nxt);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_hue_num_r <= hue_num_nxt;
      s2_sat_num_r <= sat_num_nxt;
      s2_delta_r   <= delta_nxt;
      s2_side_r    <= side_nxt;
    end
  end

  // ---- dividers ----
  rhc_divider u_hue_div (
    .clk        (clk),
    .en         (advance),
    .in_num     (s2_hue_num_r),
    .in_den     (s2_delta_r),
    .out_quot   (hue_quot),
    .out_rem_nz (hue_rem_nz)
  );

  rhc_divider u_sat_div (
    .clk        (clk),
    .en         (advance),
    .in_num     (s2_sat_num_r),
    .in_den     (s2_side_r.max_val),
    .out_quot   (sat_quot),
    .out_rem_nz (sat_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      div_side_r[0] <= s2_side_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_side_r[i] <= div_side_r[i-1];
      end
    end
  end

  // ---- hue offset, wrap and output ----
  assign last_side = div_side_r[DIV_STAGES-1];

  always_comb begin
    if (last_side.neg) begin
      // Floor of a negative quotient: step down once more on a remainder.
      hue_sum = {1'b0, last_side.offset} - (HUE_W+1)'(hue_quot)
                - (HUE_W+1)'(hue_rem_nz);
      if (hue_sum[HUE_W]) hue_sum = hue_sum + HUE_FULL_CIRCLE;
    end else begin
      hue_sum = {1'b0, last_side.offset} + (HUE_W+1)'(hue_quot);
    end
    hue_nxt = last_side.grey ? '0 : hue_sum[HUE_W-1:0];
    // Remainder plays no part in the floored saturation.
    sat_nxt = (last_side.max_val == '0) ? '0 : sat_quot[CHAN_W-1:0] | {CHAN_W{1'b0 & sat_rem_nz}};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hue_r    <= hue_nxt;
      out_sat_r    <= sat_nxt;
      out_bright_r <= last_side.max_val;
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        div_valid_r[i] <= 1'b0;
      end
    end else if (advance) begin
      s1_valid_r     <= in_valid;
      s2_valid_r     <= s1_valid_r;
      div_valid_r[0] <= s2_valid_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_valid_r[i] <= div_valid_r[i-1];
      end
      out_valid_r <= div_valid_r[DIV_STAGES-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bright_r;

endmodule

[rtl/core/rhc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker import rhc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [HUE_W-1:0]  out_hue,
  input logic [CHAN_W-1:0] out_saturation,
  input logic [CHAN_W-1:0] out_brightness
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // The pipeline holds only when a finished result is refused.
  a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // Hue stays on the circle, and a colored hue implies some saturation.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < 15'd23040) && (out_hue == '0 || out_saturation != '0))
    else $error("hue out of range or hue without saturation");

  // Black gives zero hue and zero saturation.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_saturation == '0 && out_hue == '0)
    else $error("black pixel with hue or saturation");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue)
      && $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled result changed");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
